// ===== src/sir_pkg.sv =====
`timescale 1ns / 1ps

package sir_pkg;

    localparam int unsigned GROUP_BYTES = 8;
    localparam int unsigned GRP_POS_W   = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned EV_W        = 3;
    localparam int unsigned ACK_W       = 2;
    localparam int unsigned RETRY_W     = 4;
    localparam int unsigned HDR_CNT_W   = 3;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [ADDR_W-1:0]  LOAD_BASE_RST   = 32'h0008_0000;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd5;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST_BYTE = 3'd4;
    localparam logic [HDR_CNT_W-1:0] HDR_LEN_BYTES = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_BASE   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT = 4'd1;

    // event codes
    localparam logic [EV_W-1:0] EV_STORE      = 3'd0;
    localparam logic [EV_W-1:0] EV_GROUP_OK   = 3'd1;
    localparam logic [EV_W-1:0] EV_RETRY      = 3'd2;
    localparam logic [EV_W-1:0] EV_ABORT      = 3'd3;
    localparam logic [EV_W-1:0] EV_HEADER_ERR = 3'd4;
    localparam logic [EV_W-1:0] EV_COMPLETE   = 3'd5;

    // ack codes
    localparam logic [ACK_W-1:0] ACK_OK     = 2'd0;
    localparam logic [ACK_W-1:0] ACK_RESEND = 2'd1;
    localparam logic [ACK_W-1:0] ACK_ABORT  = 2'd2;

    localparam int unsigned RES_FIFO_DEPTH = 4;
    localparam int unsigned RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int unsigned RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_DATA   = 5'b00010,
        PH_CHECK  = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_STOP   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic [ACK_W-1:0]  ack;
        logic [LEN_W-1:0]  len;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       res_a;
        res_t       res_b;
    } step_res_t;

endpackage

// ===== src/serial_image_receiver_core.sv =====
`timescale 1ns / 1ps
// channel   signals                                  direction  role
// in        in_valid, in_stall, rx_byte              in         one link byte per request
// out       out_valid, out_stall, event_res,         out        one event per request
//           store_address, store_data, ack_byte,
//           image_length, last
// cfg       cfg_valid, cfg_ready, cfg_index,         in         register writes
//           cfg_data
//
// A byte is registered on accept and decoded once the result queue has room; its 0 to 2
// events then enter the 4-entry result queue together.
// One byte per cycle is sustained while out_stall is low and each byte yields at most one
// event; a byte that yields two (image end) fills two queue entries at once.
// Reset returns the receiver to the header phase and the registers to defaults.
// out_stall holds the queue head; the input stalls when the queue cannot take two.

module serial_image_receiver_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sir_pkg::BYTE_W-1:0]         rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sir_pkg::EV_W-1:0]           event_res,
    output logic [sir_pkg::ADDR_W-1:0]         store_address,
    output logic [sir_pkg::BYTE_W-1:0]         store_data,
    output logic [sir_pkg::ACK_W-1:0]          ack_byte,
    output logic [sir_pkg::LEN_W-1:0]          image_length,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sir_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sir_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                           in_valid_reg, in_valid_next;
    logic [sir_pkg::BYTE_W-1:0]     rx_byte_reg;
    logic [sir_pkg::ADDR_W-1:0]     load_base_reg;
    logic [sir_pkg::RETRY_W-1:0]    retry_limit_reg;
    logic                           room;
    logic                           fire;
    logic                           in_accept;
    sir_pkg::step_res_t             step_res;
    sir_pkg::res_t                  head;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            rx_byte_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_base_reg   <= sir_pkg::LOAD_BASE_RST;
            retry_limit_reg <= sir_pkg::RETRY_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sir_pkg::CFG_LOAD_BASE:   load_base_reg   <= cfg_data;
                sir_pkg::CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[sir_pkg::RETRY_W-1:0];
                default:                  ;  // drop writes to unknown indexes
            endcase
        end
    end

    sir_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .rx_byte     (rx_byte_reg),
        .load_base   (load_base_reg),
        .retry_limit (retry_limit_reg),
        .step_res    (step_res)
    );

    sir_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step_res),
        .pop        (!out_stall),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign event_res     = head.ev;
    assign store_address = head.addr;
    assign store_data    = head.data;
    assign ack_byte      = head.ack;
    assign image_length  = head.len;
    assign last          = head.last;

endmodule

// ===== src/sir_step.sv =====
`timescale 1ns / 1ps

module sir_step (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  logic [sir_pkg::BYTE_W-1:0]       rx_byte,
    input  logic [sir_pkg::ADDR_W-1:0]       load_base,
    input  logic [sir_pkg::RETRY_W-1:0]      retry_limit,
    output sir_pkg::step_res_t               step_res
);

    sir_pkg::phase_t                  phase_reg, phase_next;
    logic [sir_pkg::HDR_CNT_W-1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [sir_pkg::BYTE_W-1:0]       hdr_par_reg, hdr_par_next;
    logic [sir_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [sir_pkg::LEN_W-1:0]        idx_reg, idx_next;
    logic [sir_pkg::GRP_POS_W-1:0]    gpos_reg, gpos_next;
    logic [sir_pkg::BYTE_W-1:0]       gchk_reg, gchk_next;
    logic [sir_pkg::RETRY_W-1:0]      fail_reg, fail_next;

    logic [sir_pkg::LEN_W-1:0]        idx_inc;
    logic [sir_pkg::BYTE_W-1:0]       par_new;
    logic [sir_pkg::LEN_W-1:0]        len_shift;

    assign idx_inc   = idx_reg + sir_pkg::LEN_W'(1);
    assign par_new   = hdr_par_reg ^ rx_byte;
    assign len_shift = (hdr_cnt_reg < sir_pkg::HDR_LEN_BYTES)
                       ? {len_reg[sir_pkg::LEN_W-sir_pkg::BYTE_W-1:0], rx_byte} : len_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        hdr_par_next = hdr_par_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        gpos_next    = gpos_reg;
        gchk_next    = gchk_reg;
        fail_next    = fail_reg;
        step_res     = '0;

        unique case (phase_reg) inside
            sir_pkg::PH_HEADER:
            begin
                hdr_par_next = par_new;
                len_next     = len_shift;
                hdr_cnt_next = hdr_cnt_reg + sir_pkg::HDR_CNT_W'(1);
                if (hdr_cnt_reg == sir_pkg::HDR_LAST_BYTE)
                begin
                    if (par_new != '0)
                    begin
                        step_res.count        = 2'd1;
                        step_res.res_a.ev     = sir_pkg::EV_HEADER_ERR;
                        phase_next            = sir_pkg::PH_STOP;
                    end
                    else if (len_shift == '0)
                    begin
                        step_res.count        = 2'd1;
                        step_res.res_a.ev     = sir_pkg::EV_COMPLETE;
                        phase_next            = sir_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = sir_pkg::PH_DATA;
                    end
                end
            end
            sir_pkg::PH_DATA:
            begin
                step_res.count      = 2'd1;
                step_res.res_a.ev   = sir_pkg::EV_STORE;
                step_res.res_a.addr = load_base + idx_reg;
                step_res.res_a.data = rx_byte;
                gchk_next           = gchk_reg ^ rx_byte;
                idx_next            = idx_inc;
                if (gpos_reg == sir_pkg::GRP_POS_W'(sir_pkg::GROUP_BYTES - 1))
                begin
                    // group full: the check byte comes next, even at image end
                    gpos_next  = '0;
                    phase_next = sir_pkg::PH_CHECK;
                end
                else
                begin
                    gpos_next = gpos_reg + sir_pkg::GRP_POS_W'(1);
                    if (idx_inc >= len_reg)
                    begin
                        step_res.count     = 2'd2;
                        step_res.res_b.ev  = sir_pkg::EV_COMPLETE;
                        step_res.res_b.len = len_reg;
                        phase_next         = sir_pkg::PH_DONE;
                    end
                end
            end
            sir_pkg::PH_CHECK:
            begin
                step_res.count = 2'd1;
                if (rx_byte == gchk_reg)
                begin
                    fail_next         = '0;
                    gchk_next         = '0;
                    step_res.res_a.ev = sir_pkg::EV_GROUP_OK;
                    if (idx_reg >= len_reg)
                    begin
                        step_res.count     = 2'd2;
                        step_res.res_b.ev  = sir_pkg::EV_COMPLETE;
                        step_res.res_b.len = len_reg;
                        phase_next         = sir_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = sir_pkg::PH_DATA;
                    end
                end
                else if (fail_reg >= retry_limit)
                begin
                    step_res.res_a.ev  = sir_pkg::EV_ABORT;
                    step_res.res_a.ack = sir_pkg::ACK_ABORT;
                    phase_next         = sir_pkg::PH_STOP;
                end
                else
                begin
                    // rewind to the group start and clear the running check
                    fail_next          = fail_reg + sir_pkg::RETRY_W'(1);
                    idx_next           = idx_reg - sir_pkg::LEN_W'(sir_pkg::GROUP_BYTES);
                    gchk_next          = '0;
                    step_res.res_a.ev  = sir_pkg::EV_RETRY;
                    step_res.res_a.ack = sir_pkg::ACK_RESEND;
                    phase_next         = sir_pkg::PH_DATA;
                end
            end
            sir_pkg::PH_DONE, sir_pkg::PH_STOP:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (step_res.count == 2'd2)
            step_res.res_b.last = 1'b1;
        else if (step_res.count == 2'd1)
            step_res.res_a.last = 1'b1;

        if (!fire)
            step_res.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sir_pkg::PH_HEADER;
            hdr_cnt_reg <= '0;
            hdr_par_reg <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            gpos_reg    <= '0;
            gchk_reg    <= '0;
            fail_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            hdr_par_reg <= hdr_par_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            gpos_reg    <= gpos_next;
            gchk_reg    <= gchk_next;
            fail_reg    <= fail_next;
        end
    end

endmodule

// ===== src/sir_res_fifo.sv =====
`timescale 1ns / 1ps

module sir_res_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  sir_pkg::step_res_t push,
    input  logic               pop,
    output logic               room,
    output logic               head_valid,
    output sir_pkg::res_t      head
);

    sir_pkg::res_t                 entries_reg [sir_pkg::RES_FIFO_DEPTH];
    logic [sir_pkg::RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sir_pkg::RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sir_pkg::RES_CNT_W-1:0] count_reg, count_next;
    logic [sir_pkg::RES_PTR_W-1:0] wr_ptr_b;
    logic                          do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    // leave space for the two results a single request can produce
    assign room       = (count_reg <= sir_pkg::RES_CNT_W'(sir_pkg::RES_FIFO_DEPTH - 2));
    assign do_pop     = pop && head_valid;
    assign wr_ptr_b   = wr_ptr_reg + sir_pkg::RES_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + sir_pkg::RES_PTR_W'(push.count);
        rd_ptr_next = do_pop ? rd_ptr_reg + sir_pkg::RES_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + sir_pkg::RES_CNT_W'(push.count)
                      - sir_pkg::RES_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries_reg[wr_ptr_reg] <= push.res_a;
        if (push.count == 2'd2)
            entries_reg[wr_ptr_b] <= push.res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/sir_checker.sv =====
`timescale 1ns / 1ps

module sir_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [sir_pkg::EV_W-1:0]           event_res,
    input logic [sir_pkg::ADDR_W-1:0]         store_address,
    input logic [sir_pkg::BYTE_W-1:0]         store_data,
    input logic [sir_pkg::ACK_W-1:0]          ack_byte,
    input logic                               last
);

    // hold a stalled event
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res)
                                   && $stable(store_address) && $stable(last))
        else $error("stalled event changed");

    a_ack_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_res == sir_pkg::EV_RETRY) == (ack_byte == sir_pkg::ACK_RESEND))
                      && ((event_res == sir_pkg::EV_ABORT) == (ack_byte == sir_pkg::ACK_ABORT)))
        else $error("ack byte does not match event");

    a_store_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != sir_pkg::EV_STORE) |-> store_address == '0
                                                          && store_data == '0)
        else $error("store fields set on a non-store event");

    a_single_events: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == sir_pkg::EV_RETRY || event_res == sir_pkg::EV_ABORT
                      || event_res == sir_pkg::EV_HEADER_ERR) |-> last)
        else $error("retry, abort or header error not flagged last");

    a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == sir_pkg::EV_COMPLETE) |-> last)
        else $error("image complete not flagged last");

endmodule

bind serial_image_receiver_core sir_checker u_sir_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .store_address (store_address),
    .store_data    (store_data),
    .ack_byte      (ack_byte),
    .last          (last)
);
